// File: hw/rtl/bmf_pkg.sv
`timescale 1ns / 1ps
package bmf_pkg;

  // Register map (index in units of 32-bit words)
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int KERNEL_W = 3;
  localparam int DIM_W    = 11;
  localparam int PIX_W    = 8;

  localparam logic [1:0] CFG_KERNEL = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [KERNEL_W-1:0] KERNEL_RESET = 3'd3;
  localparam logic [DIM_W-1:0]    WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RESET = 11'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

endpackage

// File: hw/rtl/bmf_queue.sv
`timescale 1ns / 1ps
module bmf_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   slots [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CNW-1:0] count;

  assign full     = (count == CNW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/bmf_front.sv
`timescale 1ns / 1ps
module bmf_front #(
  parameter int KW = 3,
  parameter int DW = 11,
  parameter int HW = 11,
  parameter int CW = 20,
  parameter int QW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic [DW-1:0]               w,
  input  logic [HW-1:0]               hgt,
  input  logic [KW-1:0]               h,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [bmf_pkg::PIX_W-1:0]   pixel_value,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [QW-1:0]               q_data
);
  import bmf_pkg::*;

  localparam logic [2:0] S_TOT   = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam int STW = $clog2(CW + 1);

  logic [2:0]       state;
  logic             op_q;
  logic [PIX_W-1:0] pix_q;
  logic [HW-1:0]    in_row;
  logic [DW-1:0]    in_col;
  logic [CW-1:0]    cnt;
  logic [HW-1:0]    r;
  logic [DW-1:0]    c;
  logic [CW-1:0]    total;
  logic [CW-1:0]    arrived;
  logic [CW-1:0]    needed;
  logic             wr_q;
  logic [KW-1:0]    wslot_q;
  logic [DW-1:0]    wcol_q;
  logic [STW-1:0]   dstep;
  logic [DW-1:0]    drem;
  logic [CW-1:0]    dquo;

  logic [CW-1:0]    w_x;
  logic [CW-1:0]    h_x;
  logic [DW:0]      dt;
  logic             dge;
  logic             restart;
  logic [HW-1:0]    row0;
  logic [DW-1:0]    col0;
  logic             wr_now;
  logic [DW-1:0]    col1;
  logic [HW:0]      r_h;
  logic [DW:0]      c_h;
  logic [HW-1:0]    nrow;
  logic [DW-1:0]    ncol;
  logic             done;
  logic             emit;
  logic             last;
  logic [CW-1:0]    cnt1;

  assign w_x = CW'(w);
  assign h_x = CW'(hgt);

  always_comb begin
    dt      = {drem, dquo[CW-1]};
    dge     = (dt >= {1'b0, w});
    restart = (in_row >= hgt) && (cnt >= total);
    row0    = restart ? '0 : in_row;
    col0    = restart ? '0 : in_col;
    wr_now  = (row0 < hgt) && (op_q == OP_PIXEL);
    col1    = col0 + 1'b1;
    r_h     = {1'b0, r} + (HW + 1)'(h);
    c_h     = {1'b0, c} + (DW + 1)'(h);
    nrow    = (r_h < (HW + 1)'(hgt - 1'b1)) ? HW'(r_h) : (hgt - 1'b1);
    ncol    = (c_h < (DW + 1)'(w - 1'b1)) ? DW'(c_h) : (w - 1'b1);
    done    = (in_row >= hgt);
    emit    = (cnt < total) && (done || (arrived >= needed));
    last    = (cnt == total - 1'b1);
    cnt1    = cnt + 1'b1;
  end

  assign in_ready = (state == S_IDLE) && !q_full && !cfg_wr;
  assign q_push   = (state == S_DEC);
  assign q_data   = {wr_q, wslot_q, wcol_q, pix_q, emit, last, r, c};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_TOT;
      in_row <= '0;
      in_col <= '0;
      cnt    <= '0;
      r      <= '0;
      c      <= '0;
      wr_q   <= 1'b0;
    end else if (cfg_wr) begin
      state <= S_TOT;
    end else begin
      case (state)
        S_TOT: begin
          total <= w_x * h_x;
          dquo  <= cnt;
          drem  <= '0;
          dstep <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit per cycle: recover row and column of the next output
          dquo  <= {dquo[CW-2:0], dge};
          drem  <= dge ? DW'(dt - {1'b0, w}) : DW'(dt);
          dstep <= dstep + 1'b1;
          if (dstep == STW'(CW - 1)) begin
            r     <= HW'({dquo[CW-2:0], dge});
            c     <= dge ? DW'(dt - {1'b0, w}) : DW'(dt);
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_q  <= op;
            pix_q <= pixel_value;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          wr_q    <= wr_now;
          wslot_q <= row0[KW-1:0];
          wcol_q  <= col0;
          if (restart) begin
            cnt <= '0;
            r   <= '0;
            c   <= '0;
          end
          if (wr_now) begin
            if (col1 >= w) begin
              in_col <= '0;
              in_row <= row0 + 1'b1;
            end else begin
              in_col <= col1;
              in_row <= row0;
            end
          end else begin
            in_col <= col0;
            in_row <= row0;
          end
          state <= S_MUL1;
        end
        S_MUL1: begin
          arrived <= CW'(in_row) * w_x + CW'(in_col);
          state   <= S_MUL2;
        end
        S_MUL2: begin
          needed <= CW'(nrow) * w_x + CW'(ncol) + 1'b1;
          state  <= S_DEC;
        end
        S_DEC: begin
          if (emit) begin
            cnt <= cnt1;
            if (c + 1'b1 >= w) begin
              c <= '0;
              r <= r + 1'b1;
            end else begin
              c <= c + 1'b1;
            end
          end
          if (done && ((emit ? cnt1 : cnt) >= total)) begin
            in_row <= '0;
            in_col <= '0;
            cnt    <= '0;
            r      <= '0;
            c      <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_TOT;
      endcase
    end
  end

endmodule

// File: hw/rtl/bmf_back.sv
`timescale 1ns / 1ps
module bmf_back #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int KW = 3,
  parameter int DW = 11,
  parameter int HW = 11,
  parameter int QW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic [QW-1:0]             q_data,
  input  logic [KW-1:0]             k,
  input  logic [KW-1:0]             h,
  input  logic [DW-1:0]             w,
  input  logic [HW-1:0]             hgt,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bmf_pkg::PIX_W-1:0] mean_value,
  output logic                      frame_last
);
  import bmf_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_WR   = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_ACC  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  localparam int ROWS  = 2 ** KW;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int KKW   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int STW   = $clog2(SW + 1);

  logic [PIX_W-1:0] mem [DEPTH];

  logic [2:0]       state;
  logic             e_wr;
  logic [KW-1:0]    e_slot;
  logic [DW-1:0]    e_col;
  logic [PIX_W-1:0] e_pix;
  logic             e_emit;
  logic             e_last;
  logic [HW-1:0]    e_r;
  logic [DW-1:0]    e_c;
  logic [KW-1:0]    di;
  logic [KW-1:0]    dj;
  logic             rd_pend;
  logic [PIX_W-1:0] rdata;
  logic [SW-1:0]    acc;
  logic [SW-1:0]    quo;
  logic [KKW-1:0]   rem;
  logic [STW-1:0]   step;

  logic [KKW-1:0]       kk;
  logic [KW:0]          two_h;
  logic signed [HW+1:0] nr;
  logic signed [DW+1:0] nc;
  logic                 inb;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [KKW:0]         t;
  logic                 ge;

  always_comb begin
    kk    = KKW'(k) * KKW'(k);
    two_h = {h, 1'b0};
    nr    = signed'((HW + 2)'(e_r)) - signed'((HW + 2)'(h)) + signed'((HW + 2)'(di));
    nc    = signed'((DW + 2)'(e_c)) - signed'((DW + 2)'(h)) + signed'((DW + 2)'(dj));
    inb   = (nr >= 0) && (nr < signed'((HW + 2)'(hgt)))
         && (nc >= 0) && (nc < signed'((DW + 2)'(w)));
    raddr = AW'(nr[KW-1:0]) * AW'(MAX_WIDTH) + AW'(nc[DW-1:0]);
    waddr = AW'(e_slot) * AW'(MAX_WIDTH) + AW'(e_col);
    t     = {rem, quo[SW-1]};
    ge    = (t >= {1'b0, kk});
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (state == B_WR && e_wr) begin
      mem[waddr] <= e_pix;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= (state == B_RD) && inb;
      if (rd_pend) begin
        acc <= acc + SW'(rdata);
      end
      if (out_valid && out_ready && (state != B_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            {e_wr, e_slot, e_col, e_pix, e_emit, e_last, e_r, e_c} <= q_data;
            state <= B_WR;
          end
        end
        B_WR: begin
          di    <= '0;
          dj    <= '0;
          acc   <= '0;
          state <= e_emit ? B_RD : B_IDLE;
        end
        B_RD: begin
          // walk the window row by row, one store read per cycle
          if ((KW + 1)'(dj) == two_h) begin
            dj <= '0;
            di <= di + 1'b1;
            if ((KW + 1)'(di) == two_h) begin
              state <= B_ACC;
            end
          end else begin
            dj <= dj + 1'b1;
          end
        end
        B_ACC: begin
          quo   <= rd_pend ? acc + SW'(rdata) : acc;
          rem   <= '0;
          step  <= '0;
          state <= B_DIV;
        end
        B_DIV: begin
          quo  <= {quo[SW-2:0], ge};
          rem  <= ge ? KKW'(t - {1'b0, kk}) : KKW'(t);
          step <= step + 1'b1;
          if (step == STW'(SW - 1)) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid || out_ready) begin
            mean_value <= (32'(quo) > 32'(PIX_MAX)) ? PIX_MAX : quo[PIX_W-1:0];
            frame_last <= e_last;
            out_valid  <= 1'b1;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/box_mean_filter_zero_pad_top.sv
`timescale 1ns / 1ps
// Channel   | Signals                                        | Transfer when
// ----------+------------------------------------------------+------------------------------
// in        | in_valid, in_ready, op, pixel_value            | in_valid && in_ready
// out       | out_valid, out_ready, mean_value, frame_last   | out_valid && out_ready
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | psel && penable && pwrite
//
// Timing: a drain tick or a pixel that releases no output passes through the apply,
// multiply and decide states of the front end. A released output then walks its window
// in the back end through the single read port of the line store and takes the
// bit-serial divide by k*k (SW quotient bits, SW = 14 for the default sizes).
// Reset and every register write start a recompute of the frame size and of the
// next output position, with in_ready low from reset or from the write cycle until
// the recompute is done.
// A two-entry queue between front and back plus the output register let input
// transfers go on while a finished result waits for out_ready.
module box_mean_filter_zero_pad_top #(
  parameter int MAX_KERNEL = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [bmf_pkg::DATA_W-1:0]   pwdata,
  output logic [bmf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         op,
  input  logic [bmf_pkg::PIX_W-1:0]    pixel_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bmf_pkg::PIX_W-1:0]    mean_value,
  output logic                         frame_last
);
  import bmf_pkg::*;

  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int QW = 1 + KW + DW + PIX_W + 1 + 1 + HW + DW;

  logic [KERNEL_W-1:0] kernel_size;
  logic [DIM_W-1:0]    frame_width;
  logic [DIM_W-1:0]    frame_height;

  logic          cfg_wr;
  logic [1:0]    cfg_idx;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] h_eff;
  logic [DW-1:0] w_eff;
  logic [HW-1:0] hgt_eff;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  // Register file: no wait states
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= KERNEL_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_KERNEL: kernel_size  <= pwdata[KERNEL_W-1:0];
        CFG_WIDTH:  frame_width  <= pwdata[DIM_W-1:0];
        CFG_HEIGHT: frame_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_KERNEL: prdata = DATA_W'(kernel_size);
      CFG_WIDTH:  prdata = DATA_W'(frame_width);
      CFG_HEIGHT: prdata = DATA_W'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, oversize clamps to the build limit.
  always_comb begin
    if (kernel_size == '0) begin
      k_eff = KW'(1);
    end else if (32'(kernel_size) > MAX_KERNEL) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(kernel_size);
    end
    h_eff = k_eff >> 1;
    if (frame_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(frame_width);
    end
    if (frame_height == '0) begin
      hgt_eff = HW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      hgt_eff = HW'(MAX_HEIGHT);
    end else begin
      hgt_eff = HW'(frame_height);
    end
  end

  // Front: track input and output positions, decide when an output is due
  bmf_front #(
    .KW(KW), .DW(DW), .HW(HW), .CW(CW), .QW(QW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_wr),
    .w           (w_eff),
    .hgt         (hgt_eff),
    .h           (h_eff),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .pixel_value (pixel_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // Hold work orders in arrival order so store writes and window reads never reorder
  bmf_queue #(
    .W(QW), .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: line store, window sum, divide, output register
  bmf_back #(
    .MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH),
    .KW(KW), .DW(DW), .HW(HW), .QW(QW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .k          (k_eff),
    .h          (h_eff),
    .w          (w_eff),
    .hgt        (hgt_eff),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_value (mean_value),
    .frame_last (frame_last)
  );

endmodule

// File: hw/rtl/bmf_checker.sv
`timescale 1ns / 1ps
module bmf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pready,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bmf_pkg::PIX_W-1:0] mean_value,
  input logic                      frame_last
);

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_value) && $stable(frame_last))
    else $error("result changed while stalled");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during recompute after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("register port stalled");

endmodule

bind box_mean_filter_zero_pad_top bmf_checker u_chk (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bmf_pkg::*;

  localparam int MAX_K     = 7;
  localparam int MAX_W     = 1024;
  localparam int MAX_H     = 1024;
  localparam int LINE_ROWS = MAX_K + 1;
  // Idle gap before a register write: worst back-end result plus slack.
  localparam int SETTLE_CYCLES = 250;
  // Longest legal silence: a long receiver hold plus a k=7 result and a recompute.
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 900;

  typedef struct packed {
    logic             drain;
    logic [PIX_W-1:0] pix;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic             last;
  } mean_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                op = OP_PIXEL;
  logic [PIX_W-1:0]    pixel_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PIX_W-1:0]    mean_value;
  logic                frame_last;

  box_mean_filter_zero_pad_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .mean_value(mean_value), .frame_last(frame_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus and expectation stores
  pixel_item_t  pixel_q[$];
  mean_result_t mean_q[$];

  // Shadow of the block: registers, line store and raster counters
  logic [KERNEL_W-1:0] cfg_kernel = KERNEL_RESET;
  logic [DIM_W-1:0]    cfg_width  = WIDTH_RESET;
  logic [DIM_W-1:0]    cfg_height = HEIGHT_RESET;
  logic [PIX_W-1:0]    line_mem [LINE_ROWS][MAX_W];
  int unsigned         in_row = 0;
  int unsigned         in_col = 0;
  int unsigned         out_idx = 0;

  int snd_idle_pct = 7;
  int rcv_idle_pct = 55;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  int n_items = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_phases = 0;
  int n_errors = 0;
  int n_sat = 0;
  int quiet_cycles = 0;

  function automatic int unsigned eff_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Advance the shadow by one accepted item; queue the mean it releases, if any.
  function automatic void filter_step(pixel_item_t it);
    int unsigned w, hg, k, hw, total, r, c, sum, mean, nrow, ncol;
    longint unsigned arrived;
    int nr, nc;
    mean_result_t res;
    w = eff_dim(cfg_width, MAX_W);
    hg = eff_dim(cfg_height, MAX_H);
    k = (cfg_kernel == 0) ? 1 : ((cfg_kernel > MAX_K) ? MAX_K : cfg_kernel);
    hw = k / 2;
    total = w * hg;
    if (in_row >= hg && out_idx >= total) begin
      in_row = 0; in_col = 0; out_idx = 0;
    end
    // Store the pixel unless the frame input is already complete.
    if (in_row < hg && it.drain == OP_PIXEL) begin
      line_mem[in_row % LINE_ROWS][in_col % MAX_W] = it.pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (out_idx >= total) return;
    r = out_idx / w;
    c = out_idx % w;
    if (in_row < hg) begin
      arrived = longint'(in_row) * w + in_col;
      nrow = (r + hw < hg - 1) ? r + hw : hg - 1;
      ncol = (c + hw < w - 1) ? c + hw : w - 1;
      if (arrived < longint'(nrow) * w + ncol + 1) return;
    end
    sum = 0;
    for (nr = int'(r) - int'(hw); nr <= int'(r) + int'(hw); nr++) begin
      for (nc = int'(c) - int'(hw); nc <= int'(c) + int'(hw); nc++) begin
        if (nr >= 0 && nr < int'(hg) && nc >= 0 && nc < int'(w))
          sum += line_mem[nr % LINE_ROWS][nc];
      end
    end
    mean = sum / (k * k);
    if (mean > PIX_MAX) begin
      mean = PIX_MAX;
      n_sat++;
    end
    res.mean = mean[PIX_W-1:0];
    res.last = (out_idx == total - 1);
    mean_q.push_back(res);
    out_idx++;
    if (res.last) n_frames++;
    if (in_row >= hg && out_idx >= total) begin
      in_row = 0; in_col = 0; out_idx = 0;
    end
  endfunction

  // Driver: predict on each input transfer, then refill or drop valid.
  always @(posedge clk) begin
    pixel_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        nxt.drain = op;
        nxt.pix = pixel_value;
        filter_step(nxt);
        n_items++;
      end
      // Offer a new item only once the current one is gone; never drop a held one.
      if (!in_valid || in_ready) begin
        if (pixel_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          nxt = pixel_q.pop_front();
          in_valid <= 1'b1;
          op <= nxt.drain;
          pixel_value <= nxt.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold that backs the pipeline up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Monitor: compare each output transfer with the oldest expected mean.
  always @(posedge clk) begin
    mean_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (mean_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected output: mean=%0d last=%0b", mean_value, frame_last);
      end else begin
        exp_r = mean_q.pop_front();
        if (exp_r.mean !== mean_value || exp_r.last !== frame_last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch at output %0d: expected mean=%0d last=%0b, got mean=%0d last=%0b",
                     n_results, exp_r.mean, exp_r.last, mean_value, frame_last);
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      CFG_KERNEL: cfg_kernel = val[KERNEL_W-1:0];
      CFG_WIDTH:  cfg_width  = val[DIM_W-1:0];
      CFG_HEIGHT: cfg_height = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every item is sent and every mean is back, then let the back end settle.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || mean_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return PIX_MAX;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Program the sizes, then queue whole frames followed by enough drain ticks.
  // fill: 0 random, 1 all max, 2 all zero. noise adds mid-frame drains and
  // a discarded pixel right after the last one.
  task automatic run_frames(int k, int w, int h, int frames, int fill, bit noise);
    int unsigned ew, eh, hw, tot, ndrain;
    pixel_item_t it;
    reg_write(CFG_KERNEL, k);
    reg_write(CFG_WIDTH, w);
    reg_write(CFG_HEIGHT, h);
    ew = eff_dim(w, MAX_W);
    eh = eff_dim(h, MAX_H);
    hw = ((k == 0) ? 1 : k) / 2;
    tot = ew * eh;
    // At most hw rows plus hw pixels of outputs trail the last pixel.
    ndrain = (hw * ew + hw + 1 < tot) ? hw * ew + hw + 1 : tot;
    ndrain++;
    for (int f = 0; f < frames; f++) begin
      for (int unsigned p = 0; p < tot; p++) begin
        if (noise && $urandom_range(0, 9) == 0) begin
          it.drain = OP_DRAIN;
          it.pix = rand_pixel();
          pixel_q.push_back(it);
        end
        it.drain = OP_PIXEL;
        it.pix = (fill == 1) ? PIX_MAX : ((fill == 2) ? '0 : rand_pixel());
        pixel_q.push_back(it);
      end
      for (int unsigned d = 0; d < ndrain; d++) begin
        // Outputs are still pending here, so this pixel must be dropped.
        it.drain = (noise && d == 0 && hw > 0 && tot > 1) ? OP_PIXEL : OP_DRAIN;
        it.pix = rand_pixel();
        pixel_q.push_back(it);
      end
    end
    n_phases++;
    wait_idle();
  endtask

  initial begin
    int k, w, h;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero sizes act as one, even kernel saturates, drains and a dropped pixel.
    run_frames(0, 0, 0, 1, 1, 1'b0);
    run_frames(2, 3, 3, 1, 1, 1'b0);
    run_frames(3, 4, 2, 1, 0, 1'b1);

    // Widest frame with a clamped width, then a tall narrow one with the largest kernel.
    run_frames(1, 2047, 0, 1, 0, 1'b0);
    run_frames(7, 1, 300, 1, 0, 1'b0);

    while (n_items < 1850) begin
      if (n_items > 1700) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (n_items > 1550) begin
        snd_idle_pct = 55;
        rcv_idle_pct = 7;
      end
      if (!hold_req && n_items > 1420) begin
        // Fill the block against a stalled receiver.
        hold_req = 1'b1;
        run_frames(3, 12, 10, 1, 0, 1'b0);
      end else begin
        k = $urandom_range(0, 7);
        w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
        h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 9);
        run_frames(k, w, h, $urandom_range(1, 2), ($urandom_range(0, 19) == 0) ? 1 : 0,
                   $urandom_range(0, 3) == 0);
      end
    end

    $display("covered %0d input transfers, %0d outputs, %0d frames over %0d size settings",
             n_items, n_results, n_frames, n_phases);
    $display("saturated means: %0d, mismatches: %0d", n_sat, n_errors);
    if (n_errors == 0 && mean_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
